// File: rtl/core/rrr_pkg.sv
`timescale 1ns / 1ps

package rrr_pkg;

  localparam int DEFAULT_CAPACITY  = 16;
  localparam int DEFAULT_TAG_WIDTH = 32;

  localparam int ACTION_W = 2;
  localparam int DATA_W   = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  localparam logic [ACTION_W-1:0] ACT_ADD     = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_REMOVE  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_ADVANCE = 2'd2;

  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  // per-step control info handed from the ring to the output stage
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                removed_valid;
    logic                cursor_valid;
    logic [COUNT_W-1:0]  entry_count;
    logic                ring_empty;
    logic                cur_bypass;
  } rrr_side_t;

endpackage

// File: rtl/core/rrr_if.sv
`timescale 1ns / 1ps

interface rrr_in_if;
  logic                         valid;
  logic                         ready;
  logic [rrr_pkg::ACTION_W-1:0] action;
  logic [rrr_pkg::DATA_W-1:0]   entry_data;

  modport source (output valid, action, entry_data, input ready);
  modport sink   (input valid, action, entry_data, output ready);
endinterface

interface rrr_out_if;
  logic                         valid;
  logic                         ready;
  logic [rrr_pkg::STATUS_W-1:0] status;
  logic                         removed_valid;
  logic [rrr_pkg::DATA_W-1:0]   removed_data;
  logic                         cursor_valid;
  logic [rrr_pkg::DATA_W-1:0]   cursor_data;
  logic [rrr_pkg::COUNT_W-1:0]  entry_count;
  logic                         ring_empty;

  modport source (output valid, status, removed_valid, removed_data, cursor_valid,
                  cursor_data, entry_count, ring_empty, input ready);
  modport sink   (input valid, status, removed_valid, removed_data, cursor_valid,
                  cursor_data, entry_count, ring_empty, output ready);
endinterface

// File: rtl/core/rrr_ram.sv
`timescale 1ns / 1ps

module rrr_ram #(
  parameter int WIDTH = rrr_pkg::DEFAULT_TAG_WIDTH,
  parameter int DEPTH = rrr_pkg::DEFAULT_CAPACITY
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read-first: a same-cycle write is not visible
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

// File: rtl/core/rrr_ring.sv
`timescale 1ns / 1ps

module rrr_ring #(
  parameter int CAPACITY  = rrr_pkg::DEFAULT_CAPACITY,
  parameter int TAG_WIDTH = rrr_pkg::DEFAULT_TAG_WIDTH
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            step,
  input  logic [rrr_pkg::ACTION_W-1:0]    action,
  input  logic [TAG_WIDTH-1:0]            tag_in,
  output logic                            ram_we,
  output logic [$clog2(CAPACITY)-1:0]     ram_waddr,
  output logic [TAG_WIDTH-1:0]            ram_wdata,
  output logic [$clog2(CAPACITY)-1:0]     raddr_rm,
  output logic [$clog2(CAPACITY)-1:0]     raddr_cur,
  output rrr_pkg::rrr_side_t              side
);

  localparam int SW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  logic [CW-1:0]       count_r, count_nxt;
  logic [SW-1:0]       first_r, first_nxt;
  logic [SW-1:0]       last_r, last_nxt;
  logic [SW-1:0]       cur_r, cur_nxt;
  logic [CAPACITY-1:0] free_r, free_nxt;

  logic [SW-1:0] next_r [CAPACITY];
  logic [SW-1:0] prev_r [CAPACITY];

  logic [SW-1:0] free_slot;
  logic          found;
  logic [SW-1:0] n_slot, p_slot;
  logic          add_ok;
  logic [rrr_pkg::STATUS_W-1:0] status;
  logic          removed_valid;
  logic          cur_bypass;

  // two link write ports per table
  logic          na_en, nb_en, pa_en, pb_en;
  logic [SW-1:0] na_addr, nb_addr, pa_addr, pb_addr;
  logic [SW-1:0] na_data, nb_data, pa_data, pb_data;

  assign n_slot = next_r[cur_r];
  assign p_slot = prev_r[cur_r];

  // lowest free slot
  always_comb begin
    free_slot = '0;
    found     = 1'b0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (free_r[i]) begin
        free_slot = SW'(i);
        found     = 1'b1;
      end
    end
  end

  always_comb begin
    count_nxt     = count_r;
    first_nxt     = first_r;
    last_nxt      = last_r;
    cur_nxt       = cur_r;
    free_nxt      = free_r;
    status        = rrr_pkg::ST_DONE;
    removed_valid = 1'b0;
    cur_bypass    = 1'b0;
    add_ok        = 1'b0;
    na_en = 1'b0; na_addr = free_slot; na_data = free_slot;
    nb_en = 1'b0; nb_addr = last_r;    nb_data = free_slot;
    pa_en = 1'b0; pa_addr = free_slot; pa_data = free_slot;
    pb_en = 1'b0; pb_addr = first_r;   pb_data = free_slot;
    case (action)
      rrr_pkg::ACT_ADD: begin
        if (!found) begin
          status = rrr_pkg::ST_FULL;
        end else begin
          add_ok              = 1'b1;
          free_nxt[free_slot] = 1'b0;
          count_nxt           = CW'(count_r + 1'b1);
          na_en               = 1'b1;
          pa_en               = 1'b1;
          if (count_r == '0) begin
            first_nxt  = free_slot;
            last_nxt   = free_slot;
            cur_nxt    = free_slot;
            cur_bypass = 1'b1;
          end else begin
            na_data  = first_r;
            pa_data  = last_r;
            nb_en    = 1'b1;
            pb_en    = 1'b1;
            last_nxt = free_slot;
          end
        end
      end
      rrr_pkg::ACT_REMOVE: begin
        if (count_r == '0) begin
          status = rrr_pkg::ST_EMPTY;
        end else begin
          removed_valid   = 1'b1;
          free_nxt[cur_r] = 1'b1;
          count_nxt       = CW'(count_r - 1'b1);
          if (count_r == CW'(1)) begin
            first_nxt = '0;
            last_nxt  = '0;
            cur_nxt   = '0;
          end else begin
            na_en   = 1'b1;
            na_addr = p_slot;
            na_data = n_slot;
            pa_en   = 1'b1;
            pa_addr = n_slot;
            pa_data = p_slot;
            if (cur_r == first_r) begin
              first_nxt = n_slot;
            end
            if (cur_r == last_r) begin
              last_nxt = p_slot;
            end
            cur_nxt = n_slot;
          end
        end
      end
      rrr_pkg::ACT_ADVANCE: begin
        if (count_r != '0) begin
          cur_nxt = n_slot;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      first_r <= '0;
      last_r  <= '0;
      cur_r   <= '0;
      free_r  <= '1;
    end else if (step) begin
      count_r <= count_nxt;
      first_r <= first_nxt;
      last_r  <= last_nxt;
      cur_r   <= cur_nxt;
      free_r  <= free_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      if (na_en) begin
        next_r[na_addr] <= na_data;
      end
      if (nb_en) begin
        next_r[nb_addr] <= nb_data;
      end
      if (pa_en) begin
        prev_r[pa_addr] <= pa_data;
      end
      if (pb_en) begin
        prev_r[pb_addr] <= pb_data;
      end
    end
  end

  assign ram_we    = step && add_ok;
  assign ram_waddr = free_slot;
  assign ram_wdata = tag_in;
  assign raddr_rm  = cur_r;
  assign raddr_cur = cur_nxt;

  assign side.status        = status;
  assign side.removed_valid = removed_valid;
  assign side.cursor_valid  = (count_nxt != '0);
  assign side.entry_count   = rrr_pkg::COUNT_W'(count_nxt);
  assign side.ring_empty    = (count_nxt == '0);
  assign side.cur_bypass    = cur_bypass;

endmodule

// File: rtl/core/rrr_outq.sv
`timescale 1ns / 1ps

module rrr_outq #(
  parameter int TAG_WIDTH = rrr_pkg::DEFAULT_TAG_WIDTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step,
  input  rrr_pkg::rrr_side_t side_in,
  input  logic [TAG_WIDTH-1:0] byp_tag,
  input  logic [TAG_WIDTH-1:0] rd_rm,
  input  logic [TAG_WIDTH-1:0] rd_cur,
  output logic               in_ready,
  rrr_out_if.source          out_bus
);

  logic                 s1_v_r, s1_v_nxt;
  rrr_pkg::rrr_side_t   s1_side_r;
  logic [TAG_WIDTH-1:0] s1_tag_r;

  logic                 o_v_r, o_v_nxt;
  rrr_pkg::rrr_side_t   o_side_r;
  logic [rrr_pkg::DATA_W-1:0] o_rm_r, o_cur_r;
  logic [rrr_pkg::DATA_W-1:0] rm_nxt, cur_nxt;

  logic o_load;

  assign o_load   = !o_v_r || out_bus.ready;
  assign in_ready = !s1_v_r || o_load;

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (step) begin
      s1_v_nxt = 1'b1;
    end else if (o_load) begin
      s1_v_nxt = 1'b0;
    end
    o_v_nxt = o_load ? s1_v_r : o_v_r;
    rm_nxt  = s1_side_r.removed_valid ? rrr_pkg::DATA_W'(rd_rm) : '0;
    cur_nxt = '0;
    if (s1_side_r.cursor_valid) begin
      cur_nxt = s1_side_r.cur_bypass ? rrr_pkg::DATA_W'(s1_tag_r)
                                     : rrr_pkg::DATA_W'(rd_cur);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      o_v_r  <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
      o_v_r  <= o_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      s1_side_r <= side_in;
      s1_tag_r  <= byp_tag;
    end
    if (o_load && s1_v_r) begin
      o_side_r <= s1_side_r;
      o_rm_r   <= rm_nxt;
      o_cur_r  <= cur_nxt;
    end
  end

  assign out_bus.valid         = o_v_r;
  assign out_bus.status        = o_side_r.status;
  assign out_bus.removed_valid = o_side_r.removed_valid;
  assign out_bus.removed_data  = o_rm_r;
  assign out_bus.cursor_valid  = o_side_r.cursor_valid;
  assign out_bus.cursor_data   = o_cur_r;
  assign out_bus.entry_count   = o_side_r.entry_count;
  assign out_bus.ring_empty    = o_side_r.ring_empty;

endmodule

// File: rtl/core/round_robin_ready_ring.sv
`timescale 1ns / 1ps
// Ring update, tag RAM read and side info are registered in stage 1; the output register
//   then holds the result on out_bus. Throughput: one beat per cycle while out_bus is ready;
//   the tag RAM read port and the output register pair set it.
// Reset (synchronous, rst_n low): ring empty, all slots free, pointers zero,
//   no result pending. Tag and link tables are not cleared.

module round_robin_ready_ring #(
  parameter int CAPACITY  = rrr_pkg::DEFAULT_CAPACITY,
  parameter int TAG_WIDTH = rrr_pkg::DEFAULT_TAG_WIDTH
) (
  input  logic       clk,
  input  logic       rst_n,
  rrr_in_if.sink     in_bus,
  rrr_out_if.source  out_bus
);

  localparam int SW = $clog2(CAPACITY);

  logic                 accept;
  logic                 in_ready;
  logic [TAG_WIDTH-1:0] tag_in;
  logic                 ram_we;
  logic [SW-1:0]        ram_waddr;
  logic [TAG_WIDTH-1:0] ram_wdata;
  logic [SW-1:0]        raddr_rm, raddr_cur;
  logic [TAG_WIDTH-1:0] rd_rm, rd_cur;
  rrr_pkg::rrr_side_t   side;

  assign in_bus.ready = in_ready;
  assign accept       = in_bus.valid && in_ready;
  assign tag_in       = TAG_WIDTH'(in_bus.entry_data);

  rrr_ring #(
    .CAPACITY  (CAPACITY),
    .TAG_WIDTH (TAG_WIDTH)
  ) u_ring (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (accept),
    .action    (in_bus.action),
    .tag_in    (tag_in),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .raddr_rm  (raddr_rm),
    .raddr_cur (raddr_cur),
    .side      (side)
  );

  rrr_ram #(
    .WIDTH (TAG_WIDTH),
    .DEPTH (CAPACITY)
  ) u_tags (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .re      (accept),
    .raddr_a (raddr_rm),
    .raddr_b (raddr_cur),
    .rdata_a (rd_rm),
    .rdata_b (rd_cur)
  );

  rrr_outq #(
    .TAG_WIDTH (TAG_WIDTH)
  ) u_outq (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (accept),
    .side_in  (side),
    .byp_tag  (tag_in),
    .rd_rm    (rd_rm),
    .rd_cur   (rd_cur),
    .in_ready (in_ready),
    .out_bus  (out_bus)
  );

  a_we_on_beat: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> accept)
    else $error("tag write without an accepted beat");

  a_bypass_hits_write: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && side.cur_bypass) |-> (ram_we && (ram_waddr == raddr_cur)))
    else $error("cursor bypass without matching tag write");

  a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_bus.valid && !out_bus.ready))
    else $error("input stalled while output is free");

  a_remove_status: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && side.removed_valid) |=> !$stable(raddr_cur) || !side.removed_valid ||
      (side.status == rrr_pkg::ST_DONE))
    else $error("remove returned an entry with a failure status");

endmodule
